// ----- rtl/bcdq_pkg.sv -----
// shared constants, types and codes of the bounded circular deque
package bcdq_pkg;

   // number of entry cells in the chain
   localparam int unsigned DEPTH = 16;
   localparam int unsigned IDX_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam int unsigned CAP_W = 5;
   localparam int unsigned ACT_W = 3;
   localparam int unsigned DATA_W = 32;

   typedef logic signed [DATA_W-1:0] data_type;

   // value shown for front and rear while the deque is empty
   localparam data_type EMPTY_VALUE = '1;

   typedef enum logic [ACT_W-1:0] {
      ACT_PUSH_FRONT = 3'd0,
      ACT_PUSH_REAR  = 3'd1,
      ACT_POP_FRONT  = 3'd2,
      ACT_POP_REAR   = 3'd3,
      ACT_QUERY      = 3'd4
   } action_type;

   // per-cycle moves of one cell
   typedef struct packed {
      logic shift_right;   // take the left neighbor's entry (push at the front)
      logic shift_left;    // take the right neighbor's entry (pop at the front)
      logic load;          // take the pushed value (push at the rear)
   } cell_ctrl_type;

endpackage

// ----- rtl/bcdq_cell.sv -----
// one entry cell of the deque chain
module bcdq_cell
   import bcdq_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  data_type      push_value,
   input  data_type      prev_value,
   input  data_type      next_value,
   output data_type      value,
   output data_type      value_next
);

   data_type value_ff;
   data_type value_in;

   // select the entry this cell holds after the current cycle
   always_comb begin
      value_in = value_ff;
      if (ctrl.load) begin
         value_in = push_value;
      end else if (ctrl.shift_right) begin
         value_in = prev_value;
      end else if (ctrl.shift_left) begin
         value_in = next_value;
      end
   end

   // entry storage, no reset needed
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value      = value_ff;
   assign value_next = value_in;

endmodule

// ----- rtl/bounded_circular_deque.sv -----
// top level of the bounded circular deque: cell chain, count, capacity, result register
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  req_action, req_value
//   rsp_      out        rsp_valid/rsp_stall  rsp_ok, rsp_front_value, rsp_rear_value,
//                                             rsp_is_empty, rsp_is_full
//   csr_      in         csr_valid/csr_ready  csr_data (capacity)
//
// one item per cycle while req_stall is low; its result shows in the result register in the cycle after the transfer.
// entries sit in a chain of cells with the front in cell 0; a front push or pop shifts
// the whole chain by one cell at the same clock edge that takes the transfer.
// reset empties the deque and sets capacity to 16; a capacity write empties it too.
// a stalled result holds the result register, and req_stall rises only while it is full.
module bounded_circular_deque
   import bcdq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [ACT_W-1:0]    req_action,
   input  data_type            req_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_ok,
   output data_type            rsp_front_value,
   output data_type            rsp_rear_value,
   output logic                rsp_is_empty,
   output logic                rsp_is_full,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CAP_W-1:0]    csr_data
);

   logic [CAP_W-1:0] capacity_ff, capacity_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] limit;
   logic             req_xfer, csr_xfer;
   logic             full_now, empty_now;
   logic             ok;
   logic             push_front, push_rear, pop_front, pop_rear;
   logic [IDX_W-1:0] rear_idx;
   cell_ctrl_type    cell_ctrl [DEPTH];
   data_type         cell_value [DEPTH];
   data_type         cell_next [DEPTH];

   logic     rsp_valid_ff, rsp_valid_in;
   logic     rsp_ok_ff, rsp_is_empty_ff, rsp_is_full_ff;
   data_type rsp_front_ff, rsp_rear_ff;

   // handshakes
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_xfer  = req_valid & ~req_stall;
   assign csr_ready = 1'b1;
   assign csr_xfer  = csr_valid & csr_ready;

   // effective capacity saturates at the chain length
   assign limit = (capacity_ff > CAP_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(capacity_ff);
   assign full_now  = count_ff >= limit;
   assign empty_now = count_ff == '0;

   // action decode
   always_comb begin
      push_front = 1'b0;
      push_rear  = 1'b0;
      pop_front  = 1'b0;
      pop_rear   = 1'b0;
      ok         = 1'b0;
      unique case (req_action)
         ACT_PUSH_FRONT: begin
            push_front = ~full_now;
            ok         = ~full_now;
         end
         ACT_PUSH_REAR: begin
            push_rear = ~full_now;
            ok        = ~full_now;
         end
         ACT_POP_FRONT: begin
            pop_front = ~empty_now;
            ok        = ~empty_now;
         end
         ACT_POP_REAR: begin
            pop_rear = ~empty_now;
            ok       = ~empty_now;
         end
         ACT_QUERY: begin
            ok = 1'b1;
         end
         default: begin
            ok = 1'b0;
         end
      endcase
   end

   // entry count and capacity
   always_comb begin
      count_in    = count_ff;
      capacity_in = capacity_ff;
      if (csr_xfer) begin
         capacity_in = csr_data;
         count_in    = '0;
      end else if (req_xfer) begin
         if (push_front | push_rear) begin
            count_in = count_ff + CNT_W'(1);
         end else if (pop_front | pop_rear) begin
            count_in = count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         capacity_ff <= CAP_W'(DEPTH);
      end else begin
         count_ff    <= count_in;
         capacity_ff <= capacity_in;
      end
   end

   // chain of cells, front entry in cell 0
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign cell_ctrl[i].shift_right = req_xfer & push_front;
      assign cell_ctrl[i].shift_left  = req_xfer & pop_front;
      assign cell_ctrl[i].load        = req_xfer & push_rear & (count_ff == CNT_W'(i));

      bcdq_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl[i]),
         .push_value (req_value),
         .prev_value ((i == 0) ? req_value : cell_value[(i == 0) ? 0 : i - 1]),
         .next_value ((i == DEPTH - 1) ? cell_value[i] : cell_value[(i == DEPTH - 1) ? i : i + 1]),
         .value      (cell_value[i]),
         .value_next (cell_next[i])
      );
   end

   // rear entry sits one cell before the new count
   assign rear_idx = IDX_W'(count_in - CNT_W'(1));

   // result register
   assign rsp_valid_in = req_xfer | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_ok_ff       <= ok;
         rsp_is_empty_ff <= count_in == '0;
         rsp_is_full_ff  <= count_in >= limit;
         rsp_front_ff    <= (count_in == '0) ? EMPTY_VALUE : cell_next[0];
         rsp_rear_ff     <= (count_in == '0) ? EMPTY_VALUE : cell_next[rear_idx];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_front_value = rsp_front_ff;
   assign rsp_rear_value  = rsp_rear_ff;
   assign rsp_is_empty    = rsp_is_empty_ff;
   assign rsp_is_full     = rsp_is_full_ff;

   // checks
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= limit)
      else $error("entry count above effective capacity");

   a_xfer_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> rsp_valid)
      else $error("transfer without result");

   a_empty_reads_minus_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> rsp_front_value == EMPTY_VALUE
                                   && rsp_rear_value == EMPTY_VALUE)
      else $error("empty result with entry values");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (pop_front || pop_rear) && !csr_xfer |=> count_ff == $past(count_ff) - 1'b1)
      else $error("pop did not shrink the count");

endmodule

// ----- bench/tb_bounded_circular_deque.sv -----
// testbench of the bounded circular deque: directed, pressure and random checks against a predictor
`timescale 1ns / 1ps

module tb_bounded_circular_deque;
   import bcdq_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200_000;
   localparam int unsigned HOLD_CYCLES = 80;
   localparam logic [ACT_W-1:0] ACT_UNUSED_FIRST = 3'd5;
   localparam logic [ACT_W-1:0] ACT_UNUSED_LAST  = 3'd7;
   localparam data_type VALUE_MIN = 32'sh8000_0000;
   localparam data_type VALUE_MAX = 32'sh7FFF_FFFF;

   // what one result shows
   typedef struct packed {
      logic     ok;
      data_type front_value;
      data_type rear_value;
      logic     is_empty;
      logic     is_full;
   } deque_view_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [ACT_W-1:0] req_action = ACT_QUERY;
   data_type         req_value = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic             rsp_ok;
   data_type         rsp_front_value;
   data_type         rsp_rear_value;
   logic             rsp_is_empty;
   logic             rsp_is_full;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CAP_W-1:0] csr_data = '0;

   // predicted deque contents
   data_type         model_slots [DEPTH];
   logic [IDX_W-1:0] model_front = '0;
   logic [CNT_W-1:0] model_count = '0;
   logic [CAP_W-1:0] model_capacity = 5'd16;

   deque_view_type   awaited_views [$];
   int unsigned      error_count = 0;
   int unsigned      cycle_count = 0;
   int unsigned      burst_left = 0;
   int unsigned      hold_req = 0;
   int unsigned      hold_seen = 0;
   int unsigned      hold_left = 0;
   int unsigned      stall_run = 0;

   bounded_circular_deque dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_ok          (rsp_ok),
      .rsp_front_value (rsp_front_value),
      .rsp_rear_value  (rsp_rear_value),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, awaited_views.size());
         $display("tb_bounded_circular_deque: done, errors");
         $finish;
      end
   end

   // apply one operation to the predicted deque and return what it shows afterwards
   function automatic deque_view_type apply_deque_op(input logic [ACT_W-1:0] act,
                                                     input data_type val);
      deque_view_type   view;
      int unsigned      lim;
      logic             ok;
      logic [IDX_W-1:0] rear_idx;
      lim = (model_capacity > DEPTH) ? DEPTH : model_capacity;
      ok = 1'b0;
      case (act)
         ACT_PUSH_FRONT: begin
            if (model_count < lim) begin
               model_front = model_front - 1'b1;
               model_slots[model_front] = val;
               model_count++;
               ok = 1'b1;
            end
         end
         ACT_PUSH_REAR: begin
            if (model_count < lim) begin
               rear_idx = model_front + model_count[IDX_W-1:0];
               model_slots[rear_idx] = val;
               model_count++;
               ok = 1'b1;
            end
         end
         ACT_POP_FRONT: begin
            if (model_count != 0) begin
               model_front = model_front + 1'b1;
               model_count--;
               ok = 1'b1;
            end
         end
         ACT_POP_REAR: begin
            if (model_count != 0) begin
               model_count--;
               ok = 1'b1;
            end
         end
         ACT_QUERY: ok = 1'b1;
         default: ok = 1'b0;
      endcase
      view.ok = ok;
      view.is_empty = (model_count == 0);
      view.is_full = (model_count >= lim);
      if (model_count == 0) begin
         view.front_value = EMPTY_VALUE;
         view.rear_value = EMPTY_VALUE;
      end else begin
         rear_idx = model_front + model_count[IDX_W-1:0] - 1'b1;
         view.front_value = model_slots[model_front];
         view.rear_value = model_slots[rear_idx];
      end
      return view;
   endfunction

   // receiver: random stall runs, clean stretches, and long holds on request
   always @(negedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen = hold_req;
         hold_left = HOLD_CYCLES;
         stall_run = 0;
      end
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (stall_run != 0) begin
         stall_run--;
      end else begin
         case ($urandom_range(0, 7))
            0, 1: begin
               rsp_stall <= 1'b1;
               stall_run = $urandom_range(0, 3);
            end
            2: begin
               rsp_stall <= 1'b0;
               stall_run = $urandom_range(40, 120);
            end
            default: begin
               rsp_stall <= 1'b0;
               stall_run = $urandom_range(0, 10);
            end
         endcase
      end
   end

   // result check on each transfer
   always @(posedge clock) begin
      deque_view_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_views.size() == 0) begin
            $display("%0t: result with none expected, got ok %b front %h rear %h",
                     $time, rsp_ok, rsp_front_value, rsp_rear_value);
            error_count++;
         end else begin
            want = awaited_views.pop_front();
            if (rsp_ok !== want.ok) begin
               $display("%0t: rsp_ok expected %b got %b", $time, want.ok, rsp_ok);
               error_count++;
            end
            if (rsp_front_value !== want.front_value) begin
               $display("%0t: rsp_front_value expected %h got %h",
                        $time, want.front_value, rsp_front_value);
               error_count++;
            end
            if (rsp_rear_value !== want.rear_value) begin
               $display("%0t: rsp_rear_value expected %h got %h",
                        $time, want.rear_value, rsp_rear_value);
               error_count++;
            end
            if (rsp_is_empty !== want.is_empty) begin
               $display("%0t: rsp_is_empty expected %b got %b",
                        $time, want.is_empty, rsp_is_empty);
               error_count++;
            end
            if (rsp_is_full !== want.is_full) begin
               $display("%0t: rsp_is_full expected %b got %b",
                        $time, want.is_full, rsp_is_full);
               error_count++;
            end
         end
      end
   end

   // offer one item, with burst gaps, and predict its result on transfer
   task automatic send_op(input logic [ACT_W-1:0] act, input data_type val);
      int unsigned gap;
      @(negedge clock);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 6);
         repeat (gap) @(negedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 16);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_value <= val;
      burst_left--;
      do @(posedge clock); while (req_stall);
      awaited_views.push_back(apply_deque_op(act, val));
   endtask

   // drop valid and wait until every result is back
   task automatic wait_idle;
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_views.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      wait_idle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= cap;
      do @(posedge clock); while (!csr_ready);
      model_capacity = cap;
      model_front = '0;
      model_count = '0;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic data_type pick_value;
      case ($urandom_range(0, 11))
         0: return VALUE_MIN;
         1: return VALUE_MAX;
         2: return EMPTY_VALUE;
         3: return '0;
         default: return $urandom;
      endcase
   endfunction

   // queries, pops and unused codes on an empty deque
   task automatic test_empty_deque;
      send_op(ACT_QUERY, '0);
      send_op(ACT_POP_FRONT, '0);
      send_op(ACT_POP_REAR, VALUE_MAX);
      for (int a = ACT_UNUSED_FIRST; a <= ACT_UNUSED_LAST; a++)
         send_op(a[ACT_W-1:0], $urandom);
   endtask

   // pushes and pops at both ends with extreme values, the empty marker among them
   task automatic test_both_ends;
      send_op(ACT_PUSH_FRONT, VALUE_MIN);
      send_op(ACT_PUSH_REAR, VALUE_MAX);
      send_op(ACT_PUSH_FRONT, EMPTY_VALUE);
      send_op(ACT_PUSH_REAR, '0);
      send_op(ACT_UNUSED_LAST, VALUE_MIN);
      send_op(ACT_QUERY, '0);
      send_op(ACT_POP_REAR, '0);
      send_op(ACT_POP_FRONT, '0);
      send_op(ACT_POP_FRONT, '0);
      send_op(ACT_POP_REAR, '0);
      send_op(ACT_POP_REAR, '0);
   endtask

   // capacity of one, capacity zero, then back to the reset value
   task automatic test_capacity_extremes;
      write_capacity(5'd1);
      send_op(ACT_PUSH_REAR, 32'sh1234_5678);
      send_op(ACT_PUSH_FRONT, VALUE_MIN);
      send_op(ACT_POP_FRONT, '0);
      write_capacity(5'd0);
      send_op(ACT_PUSH_FRONT, VALUE_MAX);
      send_op(ACT_QUERY, '0);
      write_capacity(5'd16);
   endtask

   // long receiver hold while items keep coming, then a full drain
   task automatic test_backpressure;
      hold_req++;
      burst_left = 48;
      for (int i = 0; i < 40; i++) begin
         if (i < 20)
            send_op($urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_REAR, pick_value());
         else
            send_op(ACT_W'($urandom_range(ACT_PUSH_FRONT, ACT_QUERY)), pick_value());
      end
      wait_idle();
      for (int i = 0; i < 10; i++)
         send_op(ACT_W'($urandom_range(ACT_PUSH_FRONT, ACT_QUERY)), pick_value());
      wait_idle();
   endtask

   // random operation mix over several capacities, with shifting push/pop balance
   task automatic test_random_mix;
      logic [CAP_W-1:0] phase_caps [0:8];
      int unsigned      push_weight;
      int unsigned      pick;
      logic [ACT_W-1:0] act;
      phase_caps = '{5'd16, 5'd1, 5'd5, 5'd0, 5'd31, 5'd20, 5'd3, 5'd9, 5'd16};
      push_weight = 50;
      foreach (phase_caps[p]) begin
         write_capacity(phase_caps[p]);
         for (int i = 0; i < 112; i++) begin
            if (i % 28 == 0)
               push_weight = $urandom_range(15, 85);
            pick = $urandom_range(0, 99);
            if (pick < 4)
               act = ACT_W'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
            else if (pick < 12)
               act = ACT_QUERY;
            else if ($urandom_range(0, 99) < push_weight)
               act = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_REAR;
            else
               act = $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_REAR;
            send_op(act, pick_value());
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_deque();
      test_both_ends();
      test_capacity_extremes();
      test_backpressure();
      test_random_mix();

      wait_idle();
      if (error_count == 0)
         $display("tb_bounded_circular_deque: done, clean");
      else
         $display("tb_bounded_circular_deque: done, errors");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/bcdq_pkg.sv
rtl/bcdq_cell.sv
rtl/bounded_circular_deque.sv
bench/tb_bounded_circular_deque.sv
